@@ rtl/crc_check_bit_error_count_defines.svh @@
// Assertion macros shared by the CRC check RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CRC_CHECK_BIT_ERROR_COUNT_DEFINES_SVH
`define CRC_CHECK_BIT_ERROR_COUNT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBEC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("CRC check assertion failed");

// Next-cycle implication, checked outside reset.
`define CBEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("CRC check assertion failed");

`endif

@@ rtl/cbec_pkg.sv @@
// Package for the bit-serial CRC check with error count.
// Holds payload types, control structs, register codes and helpers; no dependencies.
`default_nettype none

package cbec_pkg;

    localparam int MAX_DEGREE_DEF = 64;
    localparam int DEG_W          = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int GRP_W          = 8;
    localparam int GRP_CNT_W      = 4;

    localparam logic [CFG_DATA_W-1:0] GEN_POLY_RESET = 64'h0000_0000_0000_1021;
    localparam logic [DEG_W-1:0]      DEGREE_RESET   = 7'd16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 2'd1;

    typedef struct packed {
        logic data_bit;
        logic last_bit;
    } cbec_in_t;

    typedef struct packed {
        logic [DEG_W-1:0] error_count;
        logic             crc_ok;
    } cbec_out_t;

    // Broadcast control from the top level to every remainder cell.
    typedef struct packed {
        logic adv;
        logic clr;
        logic top;
    } cbec_ctrl_t;

    // Clamp a written degree into the range 1 to dmax.
    function automatic logic [DEG_W-1:0] clamp_degree(input logic [DEG_W-1:0] d,
                                                      input logic [DEG_W-1:0] dmax);
        logic [DEG_W-1:0] r;
        r = d;
        if (r == '0)
        begin
            r = 7'd1;
        end
        if (r > dmax)
        begin
            r = dmax;
        end
        return r;
    endfunction

    // Thermometer mask with the low d bits set.
    function automatic logic [CFG_DATA_W-1:0] degree_mask(input logic [DEG_W-1:0] d);
        logic [CFG_DATA_W-1:0] m;
        for (int i = 0; i < CFG_DATA_W; i++)
        begin
            m[i] = (DEG_W'(i) < d);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cbec_cell.sv @@
// One remainder cell of the bit-serial polynomial divider.
// Depends on cbec_pkg for the broadcast control struct.
`default_nettype none

module cbec_cell
    import cbec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cbec_ctrl_t ctrl,
    input  wire logic       prev_bit,
    input  wire logic       poly_bit,
    input  wire logic       in_use,
    output logic            rem_bit,
    output logic            rem_next
);

    logic rem_reg;

    // Shift in from the lower neighbour and fold in the generator when the top bit is set.
    // Cells above the degree load zero.
    assign rem_next = in_use & (prev_bit ^ (ctrl.top & poly_bit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            rem_reg <= ctrl.clr ? 1'b0 : rem_next;
        end
    end

    assign rem_bit = rem_reg;

endmodule

`default_nettype wire

@@ rtl/cbec_grp_count.sv @@
// Registered ones count over one eight-bit group of the final remainder.
// Depends on cbec_pkg for the group widths.
`default_nettype none

module cbec_grp_count
    import cbec_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [GRP_W-1:0]     bits,
    output logic      [GRP_CNT_W-1:0] count
);

    logic [GRP_CNT_W-1:0] count_reg;
    logic [GRP_CNT_W-1:0] count_next;

    // Small adder tree over eight bits.
    always_comb
    begin
        count_next = '0;
        for (int i = 0; i < GRP_W; i++)
        begin
            count_next = count_next + GRP_CNT_W'(bits[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

@@ rtl/crc_check_bit_error_count.sv @@
// Top level of the bit-serial CRC check with error count.
// Depends on cbec_pkg, cbec_cell, cbec_grp_count and the assertion macro header.
//
// Usage:
//   data channel   : one codeword bit a transfer (data bits, then CRC bits, highest order
//                    first); last_bit marks the final bit of a codeword.
//   result channel : one transfer a codeword, carrying the number of set remainder bits
//                    and a zero-remainder flag.
//   cfg channel    : index 0 writes the generator coefficients, index 1 the degree;
//                    always ready, other indexes are ignored.
// Throughput is one bit a cycle unless the receiver stalls: the remainder is a row of
// one-bit cells, one for each coefficient, all updated together on every data transfer.
// After the last bit is transferred, the per-group ones counts are registered, then the
// final sum goes into the output register, which offers the result.
// When the receiver stalls, the count stage and the output register fill and the data
// channel then stops; nothing is dropped.
// Reset clears the remainder and the valid flags of both pipeline stages and loads
// generator 0x1021 with degree 16. No clearing pass follows reset.
`default_nettype none

`include "crc_check_bit_error_count_defines.svh"

module crc_check_bit_error_count
    import cbec_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  data_valid,
    output logic                       data_ready,
    input  wire cbec_in_t              data,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output cbec_out_t                  result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int NGRP  = (MAX_DEGREE + GRP_W - 1) / GRP_W;
    localparam logic [DEG_W-1:0] MAX_DEG_V = DEG_W'(MAX_DEGREE);

    // Configuration registers
    logic [MAX_DEGREE-1:0] gen_reg;
    logic [DEG_W-1:0]      deg_reg;
    logic [MAX_DEGREE-1:0] mask_reg;
    logic [DEG_W-1:0]      deg_next;

    assign cfg_ready = 1'b1;
    assign deg_next  = clamp_degree(cfg_data[DEG_W-1:0], MAX_DEG_V);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg  <= MAX_DEGREE'(GEN_POLY_RESET);
            deg_reg  <= clamp_degree(DEGREE_RESET, MAX_DEG_V);
            mask_reg <= MAX_DEGREE'(degree_mask(clamp_degree(DEGREE_RESET, MAX_DEG_V)));
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_GEN_POLY)
            begin
                gen_reg <= cfg_data[MAX_DEGREE-1:0];
            end
            else if (cfg_index == REG_POLY_DEGREE)
            begin
                deg_reg  <= deg_next;
                mask_reg <= MAX_DEGREE'(degree_mask(deg_next));
            end
        end
    end

    // Pipeline handshake: count stage, then output register
    logic grp_v_reg;
    logic grp_v_next;
    logic out_v_reg;
    logic out_v_next;
    logic grp_adv;
    logic data_acc;
    logic load_grp;

    assign grp_adv    = !out_v_reg || result_ready;
    assign data_ready = !grp_v_reg || grp_adv;
    assign data_acc   = data_valid && data_ready;
    assign load_grp   = data_acc && data.last_bit;

    always_comb
    begin
        grp_v_next = grp_v_reg;
        if (load_grp)
        begin
            grp_v_next = 1'b1;
        end
        else if (grp_adv)
        begin
            grp_v_next = 1'b0;
        end
        out_v_next = out_v_reg;
        if (grp_adv)
        begin
            out_v_next = grp_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            grp_v_reg <= grp_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Row of remainder cells
    logic [MAX_DEGREE-1:0] rem_reg;
    logic [MAX_DEGREE-1:0] rem_next;
    logic [MAX_DEGREE-1:0] prev_bits;
    logic [IDX_W-1:0]      top_idx;
    cbec_ctrl_t            ctrl;

    assign top_idx   = IDX_W'(deg_reg - 7'd1);
    assign ctrl.adv  = data_acc;
    assign ctrl.clr  = data.last_bit;
    assign ctrl.top  = rem_reg[top_idx];

    generate
        for (genvar i = 0; i < MAX_DEGREE; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign prev_bits[i] = data.data_bit;
            end
            else
            begin : g_rest
                assign prev_bits[i] = rem_reg[i-1];
            end

            cbec_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .prev_bit (prev_bits[i]),
                .poly_bit (gen_reg[i]),
                .in_use   (mask_reg[i]),
                .rem_bit  (rem_reg[i]),
                .rem_next (rem_next[i])
            );
        end
    endgenerate

    // Per-group ones counts of the final remainder
    logic [NGRP*GRP_W-1:0] rem_pad;
    logic [GRP_CNT_W-1:0]  grp_cnt [NGRP];

    assign rem_pad = (NGRP*GRP_W)'(rem_next);

    generate
        for (genvar g = 0; g < NGRP; g++)
        begin : g_grp
            cbec_grp_count u_grp (
                .clk   (clk),
                .en    (load_grp),
                .bits  (rem_pad[g*GRP_W +: GRP_W]),
                .count (grp_cnt[g])
            );
        end
    endgenerate

    // Final sum into the output register
    cbec_out_t out_reg;
    cbec_out_t out_next;

    always_comb
    begin
        out_next.error_count = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            out_next.error_count = out_next.error_count + DEG_W'(grp_cnt[g]);
        end
        out_next.crc_ok = (out_next.error_count == '0);
    end

    always_ff @(posedge clk)
    begin
        if (grp_adv && grp_v_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

    // The last bit of a codeword always reaches the count stage.
    `CBEC_ASSERT_NEXT(a_last_loads_grp, load_grp, grp_v_reg)
    // The remainder is clear once a codeword has ended.
    `CBEC_ASSERT_NEXT(a_last_clears_rem, load_grp, rem_reg == '0)
    // A stalled count stage keeps its entry.
    `CBEC_ASSERT_NEXT(a_grp_holds, grp_v_reg && !grp_adv, grp_v_reg)

endmodule

`default_nettype wire

@@ tb/crc_check_bit_error_count_tb.sv @@
// Self-checking testbench for the bit-serial CRC check with error count.
// Depends on cbec_pkg and the crc_check_bit_error_count RTL; drives random valid/ready traffic.
`timescale 1ns / 100ps

module crc_check_bit_error_count_tb;
    import cbec_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int SETTLE_CYCLES  = 8;

    // Indexes outside the register list; writes to them must have no effect.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  data_valid;
    logic                  data_ready;
    cbec_in_t              data;
    logic                  result_valid;
    logic                  result_ready;
    cbec_out_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the block's registers and running remainder.
    logic [CFG_DATA_W-1:0] shadow_poly;
    logic [DEG_W-1:0]      shadow_degree;
    logic [CFG_DATA_W-1:0] shadow_rem;

    cbec_out_t expected_syndromes[$];
    int        mismatches;
    int        items_sent;
    bit        idling_on;

    crc_check_bit_error_count DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data         (data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Degree actually in force: zero acts as one, anything above the maximum saturates.
    function automatic int active_degree();
        int d;
        d = int'(shadow_degree);
        if (d < 1)
        begin
            d = 1;
        end
        if (d > MAX_DEGREE_DEF)
        begin
            d = MAX_DEGREE_DEF;
        end
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] low_bits_mask(input int d);
        if (d >= CFG_DATA_W)
        begin
            return '1;
        end
        return (64'd1 << d) - 64'd1;
    endfunction

    // One step of polynomial division under the current generator.
    function automatic logic [CFG_DATA_W-1:0] divide_step(input logic [CFG_DATA_W-1:0] r_in,
                                                           input logic b);
        int                    d;
        logic [CFG_DATA_W-1:0] m;
        logic [CFG_DATA_W-1:0] r;
        logic                  top;
        d   = active_degree();
        m   = low_bits_mask(d);
        r   = r_in & m;
        top = r[d-1];
        r   = ((r << 1) | CFG_DATA_W'(b)) & m;
        if (top)
        begin
            r = r ^ (shadow_poly & m);
        end
        return r;
    endfunction

    // Update the shadow state for one accepted codeword bit.
    task automatic predict_bit(input cbec_in_t item);
        cbec_out_t exp_res;
        shadow_rem = divide_step(shadow_rem, item.data_bit);
        if (item.last_bit)
        begin
            exp_res.error_count = DEG_W'($countones(shadow_rem));
            exp_res.crc_ok      = (shadow_rem == '0);
            expected_syndromes.push_back(exp_res);
            shadow_rem = '0;
        end
    endtask

    function automatic logic [DEG_W-1:0] pick_degree();
        int p;
        p = $urandom_range(99);
        if (p < 50)
        begin
            return DEG_W'($urandom_range(1, 8));
        end
        else if (p < 75)
        begin
            return DEG_W'($urandom_range(9, 24));
        end
        else if (p < 88)
        begin
            return DEG_W'($urandom_range(25, 63));
        end
        else if (p < 94)
        begin
            return DEG_W'(64);
        end
        else if (p < 97)
        begin
            return DEG_W'($urandom_range(65, 127));
        end
        return '0;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_poly();
        int p;
        p = $urandom_range(9);
        if (p == 0)
        begin
            return '1;
        end
        else if (p == 1)
        begin
            return '0;
        end
        else if (p == 2)
        begin
            return 64'd1;
        end
        return {$urandom, $urandom};
    endfunction

    // Send one codeword bit; called and returns at a falling edge.
    task automatic send_bit(input logic b, input logic l);
        cbec_in_t item;
        item.data_bit = b;
        item.last_bit = l;
        while (idling_on && $urandom_range(99) < 30)
        begin
            data_valid <= 1'b0;
            @(negedge clk);
        end
        data_valid <= 1'b1;
        data       <= item;
        @(posedge clk);
        while (!data_ready)
        begin
            @(posedge clk);
        end
        predict_bit(item);
        items_sent++;
        @(negedge clk);
    endtask

    // Write one configuration register; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_GEN_POLY:    shadow_poly   = val;
            REG_POLY_DEGREE: shadow_degree = val[DEG_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Degree write with random upper bits, which the block must drop.
    task automatic write_degree(input logic [DEG_W-1:0] deg);
        logic [CFG_DATA_W-1:0] v;
        v            = {$urandom, $urandom};
        v[DEG_W-1:0] = deg;
        write_reg(REG_POLY_DEGREE, v);
    endtask

    // Hold the sender off until every expected result has been transferred.
    task automatic wait_for_results();
        data_valid <= 1'b0;
        while (expected_syndromes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Data bits followed by their CRC, with some CRC bits flipped and the CRC
    // possibly cut short.
    task automatic send_codeword(input int data_len, input int flips, input int crc_len);
        int                    d;
        logic [CFG_DATA_W-1:0] crc;
        logic [CFG_DATA_W-1:0] flip_mask;
        logic                  bits[$];
        logic                  b;
        d   = active_degree();
        crc = '0;
        for (int i = 0; i < data_len; i++)
        begin
            b = 1'($urandom_range(1));
            bits.push_back(b);
            crc = divide_step(crc, b);
        end
        for (int i = 0; i < d; i++)
        begin
            crc = divide_step(crc, 1'b0);
        end
        flip_mask = '0;
        while ($countones(flip_mask) < flips)
        begin
            flip_mask[$urandom_range(d - 1)] = 1'b1;
        end
        crc = crc ^ flip_mask;
        for (int i = 0; i < data_len; i++)
        begin
            send_bit(bits[i], (crc_len == 0) && (i == data_len - 1));
        end
        for (int i = 0; i < crc_len; i++)
        begin
            send_bit(crc[d - 1 - i], i == crc_len - 1);
        end
    endtask

    // Reset values: CRC-16 generator, single-bit codewords.
    task automatic test_reset_defaults();
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b1);
        wait_for_results();
    endtask

    // Lowest degree: a parity check.
    task automatic test_parity_degree();
        write_reg(REG_GEN_POLY, '1);
        write_degree(DEG_W'(1));
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_for_results();
    endtask

    // A degree of zero behaves as degree one.
    task automatic test_zero_degree();
        write_degree('0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        wait_for_results();
    endtask

    // Largest written degree saturates to the maximum.
    task automatic test_saturated_degree();
        write_degree('1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_for_results();
    endtask

    // Full 64-bit degree with a codeword shorter than the degree.
    task automatic test_full_degree();
        write_reg(REG_GEN_POLY, 64'h0000_0000_0000_001B);
        write_degree(DEG_W'(64));
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_for_results();
    endtask

    // Writes beyond the register list leave the settings unchanged.
    task automatic test_ignored_index();
        write_reg(REG_SPARE_2, '0);
        write_reg(REG_SPARE_3, '1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        wait_for_results();
    endtask

    // Degree reduced part way through a codeword.
    task automatic test_degree_change_mid_codeword();
        write_reg(REG_GEN_POLY, 64'h0000_0000_0000_0007);
        write_degree(DEG_W'(8));
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        wait_for_results();
        write_degree(DEG_W'(3));
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_for_results();
    endtask

    // Random settings, mostly well-formed codewords with some noise and broken ones.
    task automatic test_random_traffic();
        int first;
        int d;
        int kind;
        int n;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            // Stretch with no idling on either side.
            idling_on = !((items_sent - first >= 600) && (items_sent - first < 1000));
            wait_for_results();
            write_reg(REG_GEN_POLY, pick_poly());
            write_degree(pick_degree());
            if ($urandom_range(9) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(2, 3)), {$urandom, $urandom});
            end
            repeat ($urandom_range(3, 8))
            begin
                d    = active_degree();
                kind = $urandom_range(99);
                if (kind < 75)
                begin
                    n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, d);
                    send_codeword($urandom_range(1, 10), n, d);
                end
                else if (kind < 85)
                begin
                    repeat ($urandom_range(1, 20))
                    begin
                        send_bit(1'($urandom_range(1)), $urandom_range(7) == 0);
                    end
                end
                else if (kind < 95)
                begin
                    send_codeword($urandom_range(1, 10), 0, $urandom_range(0, d - 1));
                end
                else
                begin
                    repeat ($urandom_range(1, 12))
                    begin
                        send_bit(1'($urandom_range(1)), 1'b0);
                    end
                    wait_for_results();
                    write_degree(pick_degree());
                    if ($urandom_range(1) == 0)
                    begin
                        write_reg(REG_GEN_POLY, pick_poly());
                    end
                    n = $urandom_range(1, 16);
                    for (int i = 0; i < n; i++)
                    begin
                        send_bit(1'($urandom_range(1)), i == n - 1);
                    end
                end
            end
        end
        idling_on = 1'b1;
    endtask

    // Receiver stalls at random while idling is enabled.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_ready <= idling_on ? ($urandom_range(99) >= 30) : 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        cbec_out_t exp_res;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_syndromes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result: error_count=%0d crc_ok=%0b",
                             result.error_count, result.crc_ok);
                end
            end
            else
            begin
                exp_res = expected_syndromes.pop_front();
                if (result.error_count !== exp_res.error_count ||
                    result.crc_ok !== exp_res.crc_ok)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected error_count=%0d crc_ok=%0b, got %0d %0b",
                                 exp_res.error_count, exp_res.crc_ok,
                                 result.error_count, result.crc_ok);
                    end
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        data_valid    = 1'b0;
        data          = '0;
        result_ready  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        shadow_poly   = GEN_POLY_RESET;
        shadow_degree = DEGREE_RESET;
        shadow_rem    = '0;
        mismatches    = 0;
        items_sent    = 0;
        idling_on     = 1'b1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_parity_degree();
        test_zero_degree();
        test_saturated_degree();
        test_full_degree();
        test_ignored_index();
        test_degree_change_mid_codeword();
        test_random_traffic();

        wait_for_results();
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
